FILE: src/adpa_pkg.sv
// Package: opcode and condition codes, flag positions and word constants for the DP ALU.
`default_nettype none

package adpa_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned SignBit  = WordBits - 1;
  localparam logic [3:0]  PcIndex  = 4'd15;

  // Flag bit positions within NZCV
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [3:0]          nzcv_t;

  typedef enum logic [3:0] {
    OpAnd = 4'd0,
    OpEor = 4'd1,
    OpSub = 4'd2,
    OpRsb = 4'd3,
    OpAdd = 4'd4,
    OpAdc = 4'd5,
    OpSbc = 4'd6,
    OpRsc = 4'd7,
    OpTst = 4'd8,
    OpTeq = 4'd9,
    OpCmp = 4'd10,
    OpCmn = 4'd11,
    OpOrr = 4'd12,
    OpMov = 4'd13,
    OpBic = 4'd14,
    OpMvn = 4'd15
  } alu_op_e;

  typedef enum logic [3:0] {
    CondEq = 4'd0,
    CondNe = 4'd1,
    CondCs = 4'd2,
    CondCc = 4'd3,
    CondMi = 4'd4,
    CondPl = 4'd5,
    CondVs = 4'd6,
    CondVc = 4'd7,
    CondHi = 4'd8,
    CondLs = 4'd9,
    CondGe = 4'd10,
    CondLt = 4'd11,
    CondGt = 4'd12,
    CondLe = 4'd13,
    CondAl = 4'd14,
    CondNv = 4'd15
  } cond_e;

  // Evaluate a condition code against the stored flags
  function automatic logic cond_holds(input cond_e cond, input nzcv_t f);
    logic n, z, c, v, res;
    n = f[FlagN];
    z = f[FlagZ];
    c = f[FlagC];
    v = f[FlagV];
    case (cond)
      CondEq:  res = z;
      CondNe:  res = !z;
      CondCs:  res = c;
      CondCc:  res = !c;
      CondMi:  res = n;
      CondPl:  res = !n;
      CondVs:  res = v;
      CondVc:  res = !v;
      CondHi:  res = c && !z;
      CondLs:  res = !c || z;
      CondGe:  res = (n == v);
      CondLt:  res = (n != v);
      CondGt:  res = !z && (n == v);
      CondLe:  res = z || (n != v);
      CondAl:  res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/arm_data_processing_alu.sv
// Top level: ARMv5 data-processing ALU with stored NZCV flags and a registered result.
// The result is registered: it reaches the output register in the cycle after the item is accepted.
// Throughput: one item per cycle unless the output stalls; the flag path (condition check,
// 33-bit adder, flag update) is combinational so each item sees the flags of the last.
// The input stalls only while the output register holds an item that is stalled.
// Reset (rst_ni low, asynchronous) clears the NZCV flags and the output valid.
`default_nettype none

module arm_data_processing_alu
  import adpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [31:0] instruction_i,
  input  wire logic [31:0] first_operand_i,
  input  wire logic [31:0] shifted_operand_i,
  input  wire logic        shifter_carry_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             cond_passed_o,
  output logic             write_enable_o,
  output logic [3:0]       dest_register_o,
  output logic [31:0]      result_value_o,
  output logic [3:0]       flags_out_o
);

  // Stored flags and output register
  nzcv_t flags_q, flags_d;
  logic  out_valid_q;
  logic  cond_passed_q, cond_passed_d;
  logic  write_enable_q, write_enable_d;
  logic  [3:0] dest_q;
  word_t result_q, result_d;
  nzcv_t flags_out_q;

  logic in_accept;

  // Instruction fields
  cond_e      cond;
  alu_op_e    opc;
  logic       s_bit;
  logic [3:0] rd;
  logic [3:0] rot;
  logic [4:0] rot_amt;
  logic [2*WordBits-1:0] imm_dbl;

  word_t op_a, op_b, imm_rot;
  logic  shift_c, cflag;

  // Adder operands
  word_t       add_x, add_y;
  logic        add_cin;
  logic [WordBits:0] add_sum;
  word_t       add_r;
  logic        add_c, add_v;

  logic  arith, writes;
  logic  res_c, res_v;
  logic  upd_flags;
  nzcv_t new_flags;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cond  = cond_e'(instruction_i[31:28]);
  assign opc   = alu_op_e'(instruction_i[24:21]);
  assign s_bit = instruction_i[20];
  assign rd    = instruction_i[15:12];
  assign rot   = instruction_i[11:8];
  assign cflag = flags_q[FlagC];

  // Form the second operand and shifter carry
  assign rot_amt = {rot, 1'b0};
  assign imm_dbl = {{(WordBits-8){1'b0}}, instruction_i[7:0],
                    {(WordBits-8){1'b0}}, instruction_i[7:0]};

  always_comb begin
    imm_rot = imm_dbl[WordBits-1:0];
    imm_rot = word_t'(imm_dbl >> rot_amt);
    if (mode_i) begin
      op_b    = shifted_operand_i;
      shift_c = shifter_carry_i;
    end else begin
      op_b    = imm_rot;
      shift_c = (rot == 4'd0) ? cflag : imm_rot[SignBit];
    end
  end

  assign op_a = first_operand_i;

  // Select adder inputs per opcode
  always_comb begin
    case (opc)
      OpSub, OpCmp: begin
        add_x = op_a;  add_y = ~op_b; add_cin = 1'b1;
      end
      OpRsb: begin
        add_x = op_b;  add_y = ~op_a; add_cin = 1'b1;
      end
      OpAdc: begin
        add_x = op_a;  add_y = op_b;  add_cin = cflag;
      end
      OpSbc: begin
        add_x = op_a;  add_y = ~op_b; add_cin = cflag;
      end
      OpRsc: begin
        add_x = op_b;  add_y = ~op_a; add_cin = cflag;
      end
      default: begin
        add_x = op_a;  add_y = op_b;  add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{WordBits{1'b0}}, add_cin};
  assign add_r   = add_sum[WordBits-1:0];
  assign add_c   = add_sum[WordBits];
  assign add_v   = (add_x[SignBit] ^ add_r[SignBit]) & (add_y[SignBit] ^ add_r[SignBit]);

  // Compute the result and write qualifier
  always_comb begin
    arith  = 1'b0;
    writes = 1'b1;
    case (opc)
      OpAnd:   result_d = op_a & op_b;
      OpEor:   result_d = op_a ^ op_b;
      OpTst: begin
        result_d = op_a & op_b;
        writes   = 1'b0;
      end
      OpTeq: begin
        result_d = op_a ^ op_b;
        writes   = 1'b0;
      end
      OpCmp, OpCmn: begin
        result_d = add_r;
        arith    = 1'b1;
        writes   = 1'b0;
      end
      OpOrr:   result_d = op_a | op_b;
      OpMov:   result_d = op_b;
      OpBic:   result_d = op_a & ~op_b;
      OpMvn:   result_d = ~op_b;
      default: begin
        result_d = add_r;
        arith    = 1'b1;
      end
    endcase
  end

  assign res_c = arith ? add_c : shift_c;
  assign res_v = arith ? add_v : flags_q[FlagV];

  assign new_flags = {result_d[SignBit], (result_d == '0), res_c, res_v};

  // Decide on execution and the flag update
  always_comb begin
    cond_passed_d  = cond_holds(cond, flags_q);
    write_enable_d = cond_passed_d && writes;
    upd_flags      = cond_passed_d && s_bit && !(writes && (rd == PcIndex));
    flags_d        = upd_flags ? new_flags : flags_q;
  end

  // Hold the flags; advance them on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        flags_q     <= flags_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output payload on acceptance
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cond_passed_q  <= cond_passed_d;
      write_enable_q <= write_enable_d;
      dest_q         <= rd;
      result_q       <= cond_passed_d ? result_d : '0;
      flags_out_q    <= flags_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cond_passed_o   = cond_passed_q;
  assign write_enable_o  = write_enable_q;
  assign dest_register_o = dest_q;
  assign result_value_o  = result_q;
  assign flags_out_o     = flags_out_q;

endmodule

`default_nettype wire

FILE: dv/arm_data_processing_alu_tb.sv
// Testbench for the data-processing ALU: directed and random items with a flag predictor.
module arm_data_processing_alu_tb;
  import adpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned IdlePct    = 17;

  typedef struct packed {
    logic       cond_passed;
    logic       write_enable;
    logic [3:0] dest_register;
    word_t      result_value;
    nzcv_t      flags_out;
  } alu_result_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic        mode_i            = 1'b0;
  logic [31:0] instruction_i     = '0;
  logic [31:0] first_operand_i   = '0;
  logic [31:0] shifted_operand_i = '0;
  logic        shifter_carry_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic        cond_passed_o;
  logic        write_enable_o;
  logic [3:0]  dest_register_o;
  logic [31:0] result_value_o;
  logic [3:0]  flags_out_o;

  // Predictor state and the results still owed by the block
  nzcv_t       arch_flags = '0;
  alu_result_t pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic        in_idle_en   = 1'b1;
  logic        out_stall_en = 1'b1;

  arm_data_processing_alu i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .instruction_i     (instruction_i),
    .first_operand_i   (first_operand_i),
    .shifted_operand_i (shifted_operand_i),
    .shifter_carry_i   (shifter_carry_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cond_passed_o     (cond_passed_o),
    .write_enable_o    (write_enable_o),
    .dest_register_o   (dest_register_o),
    .result_value_o    (result_value_o),
    .flags_out_o       (flags_out_o)
  );

  // Toggle the clock every half period
  always #1 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= out_stall_en && ($urandom_range(99) < IdlePct);
  end

  // Evaluate a condition field against a flag set
  function automatic logic cond_met(input cond_e cond, input nzcv_t f);
    logic n, z, c, v;
    n = f[FlagN];
    z = f[FlagZ];
    c = f[FlagC];
    v = f[FlagV];
    case (cond)
      CondEq: return z;
      CondNe: return ~z;
      CondCs: return c;
      CondCc: return ~c;
      CondMi: return n;
      CondPl: return ~n;
      CondVs: return v;
      CondVc: return ~v;
      CondHi: return c & ~z;
      CondLs: return ~c | z;
      CondGe: return n ~^ v;
      CondLt: return n ^ v;
      CondGt: return ~z & (n ~^ v);
      CondLe: return z | (n ^ v);
      CondAl: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // 33-bit add with carry out and signed overflow
  function automatic word_t sum33(input word_t x, input word_t y, input logic cin,
                                  output logic co, output logic ov);
    logic [32:0] s;
    s  = {1'b0, x} + {1'b0, y} + {32'b0, cin};
    co = s[32];
    ov = (x[SignBit] == y[SignBit]) && (s[SignBit] != x[SignBit]);
    return s[31:0];
  endfunction

  // Compute the result of one instruction and advance the predicted flags
  function automatic alu_result_t execute_instruction(input logic mode, input word_t ins,
                                                      input word_t a, input word_t sh,
                                                      input logic shc);
    alu_op_e     op;
    logic [3:0]  rot;
    logic [63:0] spun;
    word_t       b, r, imm;
    logic        sc, c, v, writes, cin;
    nzcv_t       f;
    alu_result_t res;
    op  = alu_op_e'(ins[24:21]);
    f   = arch_flags;
    cin = f[FlagC];
    res.cond_passed   = 1'b0;
    res.write_enable  = 1'b0;
    res.dest_register = ins[15:12];
    res.result_value  = '0;
    res.flags_out     = f;
    // Form the second operand and the shifter carry
    if (mode) begin
      b  = sh;
      sc = shc;
    end else begin
      rot  = ins[11:8];
      imm  = {24'h0, ins[7:0]};
      spun = {imm, imm} >> (2 * rot);
      b    = spun[31:0];
      sc   = (rot == 4'd0) ? cin : b[SignBit];
    end
    if (!cond_met(cond_e'(ins[31:28]), f)) return res;
    c      = sc;
    v      = f[FlagV];
    writes = 1'b1;
    case (op)
      OpAnd: r = a & b;
      OpEor: r = a ^ b;
      OpSub: r = sum33(a, ~b, 1'b1, c, v);
      OpRsb: r = sum33(b, ~a, 1'b1, c, v);
      OpAdd: r = sum33(a, b, 1'b0, c, v);
      OpAdc: r = sum33(a, b, cin, c, v);
      OpSbc: r = sum33(a, ~b, cin, c, v);
      OpRsc: r = sum33(b, ~a, cin, c, v);
      OpTst: begin r = a & b; writes = 1'b0; end
      OpTeq: begin r = a ^ b; writes = 1'b0; end
      OpCmp: begin r = sum33(a, ~b, 1'b1, c, v); writes = 1'b0; end
      OpCmn: begin r = sum33(a, b, 1'b0, c, v); writes = 1'b0; end
      OpOrr: r = a | b;
      OpMov: r = b;
      OpBic: r = a & ~b;
      default: r = ~b;
    endcase
    // Writing ops aimed at the PC keep the flags
    if (ins[20] && !(writes && ins[15:12] == PcIndex)) begin
      arch_flags = {r[SignBit], r == '0, c, v};
    end
    res.cond_passed  = 1'b1;
    res.write_enable = writes;
    res.result_value = r;
    res.flags_out    = arch_flags;
    return res;
  endfunction

  function automatic word_t encode(input cond_e cond, input alu_op_e op, input logic s,
                                   input logic [3:0] rn, input logic [3:0] rd,
                                   input logic [11:0] opnd);
    return {cond, 3'b001, op, s, rn, rd, opnd};
  endfunction

  // Pick an operand, biased toward corner values
  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return word_t'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // Present one item, hold it until accepted, then record its expected result
  task automatic send_item(input logic mode, input word_t ins, input word_t a,
                           input word_t sh, input logic shc);
    while (in_idle_en && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    mode_i            <= mode;
    instruction_i     <= ins;
    first_operand_i   <= a;
    shifted_operand_i <= sh;
    shifter_carry_i   <= shc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(execute_instruction(mode, ins, a, sh, shc));
  endtask

  task automatic send_random_item();
    word_t ins;
    ins = $urandom;
    if ($urandom_range(9) < 4) ins[31:28] = CondAl;
    send_item(1'($urandom_range(1)), ins, pick_word(), pick_word(), 1'($urandom_range(1)));
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Every opcode with S set, register form, corner operands
  task automatic test_opcodes();
    word_t corner_vals[4];
    corner_vals[0] = 32'h7FFF_FFFF;
    corner_vals[1] = 32'hFFFF_FFFF;
    corner_vals[2] = 32'h8000_0000;
    corner_vals[3] = 32'h0000_0000;
    for (int i = 0; i < 16; i++) begin
      send_item(1'b1, encode(CondAl, alu_op_e'(i), 1'b1, 4'(i), 4'(i), 12'hFFF),
                corner_vals[i % 4], corner_vals[(i / 4 + 1) % 4], 1'(i));
    end
  endtask

  // Immediate carry: stored C with no rotate, bit 31 of the rotated value otherwise
  task automatic test_immediate_carry();
    send_item(1'b0, encode(CondAl, OpCmp, 1'b1, 4'd0, 4'd0, 12'h000), 32'd1, '0, 1'b0);
    send_item(1'b0, encode(CondAl, OpMov, 1'b1, 4'd0, 4'd1, 12'h0FF), '0, '0, 1'b0);
    send_item(1'b0, encode(CondAl, OpMov, 1'b1, 4'd0, 4'd2, 12'h101), '0, '0, 1'b1);
    send_item(1'b0, encode(CondAl, OpMov, 1'b1, 4'd0, 4'd3, 12'h102), '0, '0, 1'b0);
    send_item(1'b0, encode(CondAl, OpAdd, 1'b1, 4'd0, 4'd4, 12'hFFF), 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b1);
  endtask

  // PC destination, compare into PC, never condition, failing condition
  task automatic test_special_cases();
    send_item(1'b1, encode(CondAl, OpAdd, 1'b1, 4'd1, PcIndex, 12'h0),
              32'h8000_0000, 32'h8000_0000, 1'b1);
    send_item(1'b1, encode(CondAl, OpCmp, 1'b1, 4'd1, PcIndex, 12'h0), 32'd5, 32'd5, 1'b0);
    send_item(1'b1, encode(CondNv, OpMov, 1'b1, 4'd1, 4'd2, 12'h0), '0, 32'd7, 1'b1);
    send_item(1'b1, encode(CondNe, OpMov, 1'b1, 4'd1, 4'd3, 12'h0), '0, 32'd9, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned n);
    repeat (n) send_random_item();
  endtask

  // Full-rate stretch: no gaps on either side
  task automatic test_back_to_back(input int unsigned n);
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    repeat (n) send_random_item();
    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;
  endtask

  // Pause the sender until the result side has caught up, then resume
  task automatic test_drain_pause(input int unsigned n);
    repeat (n) send_random_item();
    wait_for_drain();
    repeat (n) send_random_item();
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    alu_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatch_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (cond_passed_o !== exp_res.cond_passed) begin
          $error("cond_passed: expected %0h actual %0h", exp_res.cond_passed, cond_passed_o);
          mismatch_cnt++;
        end
        if (write_enable_o !== exp_res.write_enable) begin
          $error("write_enable: expected %0h actual %0h", exp_res.write_enable,
                 write_enable_o);
          mismatch_cnt++;
        end
        if (dest_register_o !== exp_res.dest_register) begin
          $error("dest_register: expected %0h actual %0h", exp_res.dest_register,
                 dest_register_o);
          mismatch_cnt++;
        end
        if (result_value_o !== exp_res.result_value) begin
          $error("result_value: expected %0h actual %0h", exp_res.result_value,
                 result_value_o);
          mismatch_cnt++;
        end
        if (flags_out_o !== exp_res.flags_out) begin
          $error("flags_out: expected %0h actual %0h", exp_res.flags_out, flags_out_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // End the run if nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("arm_data_processing_alu_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_opcodes();
    test_immediate_carry();
    test_special_cases();
    test_random_traffic(500);
    test_back_to_back(250);
    test_drain_pause(150);
    test_random_traffic(250);
    wait_for_drain();
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("arm_data_processing_alu_tb: done, clean");
    end else begin
      $display("arm_data_processing_alu_tb: done, errors");
    end
    $finish;
  end

endmodule
